[sv/p256der_pkg.sv]
// p256der_pkg: constants shared by the der signature check core and its checker
// holds der tags, length limits and the p-256 group order as a byte lookup
// no dependencies
`default_nettype none

package p256der_pkg;

  // der tags
  localparam logic [7:0] SEQ_TAG = 8'h30;
  localparam logic [7:0] INT_TAG = 8'h02;

  // integer length limits, a value of the order's width and one with a sign pad
  localparam logic [7:0] INT_LEN_MAX = 8'd33;
  localparam logic [7:0] ORDER_BYTES = 8'd32;

  // total signature length window
  localparam logic [7:0] MIN_DER_BYTES = 8'd8;
  localparam logic [7:0] MAX_DER_BYTES = 8'd72;

  // stream widths
  localparam int unsigned DATA_W = 8;

  // p-256 group order, most significant byte at index 0
  function automatic logic [7:0] order_byte(input logic [4:0] idx);
    logic [7:0] ob;
    case (idx)
      5'd0:    ob = 8'hff;
      5'd1:    ob = 8'hff;
      5'd2:    ob = 8'hff;
      5'd3:    ob = 8'hff;
      5'd4:    ob = 8'h00;
      5'd5:    ob = 8'h00;
      5'd6:    ob = 8'h00;
      5'd7:    ob = 8'h00;
      5'd8:    ob = 8'hff;
      5'd9:    ob = 8'hff;
      5'd10:   ob = 8'hff;
      5'd11:   ob = 8'hff;
      5'd12:   ob = 8'hff;
      5'd13:   ob = 8'hff;
      5'd14:   ob = 8'hff;
      5'd15:   ob = 8'hff;
      5'd16:   ob = 8'hbc;
      5'd17:   ob = 8'he6;
      5'd18:   ob = 8'hfa;
      5'd19:   ob = 8'had;
      5'd20:   ob = 8'ha7;
      5'd21:   ob = 8'h17;
      5'd22:   ob = 8'h9e;
      5'd23:   ob = 8'h84;
      5'd24:   ob = 8'hf3;
      5'd25:   ob = 8'hb9;
      5'd26:   ob = 8'hca;
      5'd27:   ob = 8'hc2;
      5'd28:   ob = 8'hfc;
      5'd29:   ob = 8'h63;
      5'd30:   ob = 8'h25;
      5'd31:   ob = 8'h51;
      default: ob = 8'h00;
    endcase
    return ob;
  endfunction

endpackage

`default_nettype wire

[sv/p256_ecdsa_der_signature_check_core.sv]
// p256_ecdsa_der_signature_check_core: streaming strict-der check of an ecdsa p-256 signature
// depends on p256der_pkg for tags, limits and the group order bytes
//
//   channel   | dir | beat content                         | handshake
//   ----------+-----+--------------------------------------+----------------------------
//   s_axis    | in  | tdata[7:0] signature byte, tlast end | tvalid/tready, one byte
//   m_axis    | out | tdata[0] signature valid, [7:1] zero | tvalid/tready, one per tlast
//
// one byte per cycle unless a tlast byte waits behind an untaken result; each byte
// passes an input register, one level of parse logic and, for the final byte, the
// result register; the verdict enters the result register as the tlast byte leaves
// the input register, unless it waits behind an untaken result
// rst is synchronous, active high, and returns the parser to the sequence tag
// s_axis_tready drops only while a tlast byte waits behind an untaken result
`default_nettype none

module p256_ecdsa_der_signature_check_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  wire logic       s_axis_tlast,   // last
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata    // [0] valid_res, [7:1] zero
);

  // where the parser is within the der structure
  typedef enum logic [2:0] {
    PH_SEQ_TAG,
    PH_SEQ_LEN,
    PH_INT_TAG,
    PH_INT_LEN,
    PH_INT_BODY,
    PH_DONE
  } phase_t;

  // running comparison of an integer against the group order
  typedef enum logic [1:0] {
    CMP_EQUAL,
    CMP_LESS,
    CMP_GREATER
  } cmp_t;

  // input register
  logic       in_valid;
  logic [7:0] in_data;
  logic       in_last;

  // result register
  logic out_valid;
  logic out_res;

  // parser state
  logic [7:0] byte_count;
  phase_t     parse_phase;
  logic [6:0] declared_length;
  logic       integer_number;
  logic [5:0] integer_length;
  logic [5:0] integer_bytes_left;
  logic       leading_zero_seen;
  cmp_t       order_compare;
  logic       failed;

  logic [7:0] byte_count_next;
  phase_t     parse_phase_next;
  logic [6:0] declared_length_next;
  logic       integer_number_next;
  logic [5:0] integer_length_next;
  logic [5:0] integer_bytes_left_next;
  logic       leading_zero_seen_next;
  cmp_t       order_compare_next;
  logic       failed_next;
  logic       res_next;

  logic advance;

  // a non-final byte never needs the result register, so it always moves on
  assign advance       = in_valid && (!in_last || !out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0, out_res};

  // parse logic for the byte held in the input register
  always_comb begin
    logic [5:0] pos;
    logic [5:0] left_dec;
    logic [5:0] oi_full;
    logic [7:0] ob;
    cmp_t       cmp_mid;

    byte_count_next         = (byte_count == 8'hff) ? byte_count : byte_count + 8'd1;
    parse_phase_next        = parse_phase;
    declared_length_next    = declared_length;
    integer_number_next     = integer_number;
    integer_length_next     = integer_length;
    integer_bytes_left_next = integer_bytes_left;
    leading_zero_seen_next  = leading_zero_seen;
    order_compare_next      = order_compare;
    failed_next             = failed;

    // position within the integer content and the matching order byte
    pos      = integer_length - integer_bytes_left;
    left_dec = integer_bytes_left - 6'd1;
    oi_full  = pos - integer_length;
    ob       = p256der_pkg::order_byte(oi_full[4:0]);
    cmp_mid  = order_compare;

    if (!failed) begin
      case (parse_phase)
        PH_SEQ_TAG: begin
          if (in_data != p256der_pkg::SEQ_TAG) failed_next = 1'b1;
          parse_phase_next = PH_SEQ_LEN;
        end
        PH_SEQ_LEN: begin
          // long-form lengths are not allowed
          if (in_data[7]) failed_next = 1'b1;
          declared_length_next = in_data[6:0];
          parse_phase_next     = PH_INT_TAG;
        end
        PH_INT_TAG: begin
          if (in_data != p256der_pkg::INT_TAG) failed_next = 1'b1;
          parse_phase_next = PH_INT_LEN;
        end
        PH_INT_LEN: begin
          if (in_data == 8'd0 || in_data > p256der_pkg::INT_LEN_MAX) begin
            failed_next = 1'b1;
          end else begin
            integer_length_next     = in_data[5:0];
            integer_bytes_left_next = in_data[5:0];
            leading_zero_seen_next  = 1'b0;
            order_compare_next      = CMP_EQUAL;
            parse_phase_next        = PH_INT_BODY;
          end
        end
        PH_INT_BODY: begin
          if (pos == 6'd0) begin
            // negative, a full-width value without its zero sign pad, or a lone zero
            if (in_data[7]) failed_next = 1'b1;
            if (integer_length == p256der_pkg::INT_LEN_MAX[5:0] && in_data != 8'd0)
              failed_next = 1'b1;
            if (integer_length == 6'd1 && in_data == 8'd0) failed_next = 1'b1;
            leading_zero_seen_next = (in_data == 8'd0);
            // shorter values are below the order without looking
            if (!(integer_length == p256der_pkg::INT_LEN_MAX[5:0] ||
                  (integer_length == p256der_pkg::ORDER_BYTES[5:0] && in_data != 8'd0)))
              cmp_mid = CMP_LESS;
          end else if (pos == 6'd1) begin
            // a leading zero is only allowed ahead of a high-bit byte
            if (leading_zero_seen && !in_data[7]) failed_next = 1'b1;
          end
          order_compare_next = cmp_mid;
          if (cmp_mid == CMP_EQUAL &&
              ({1'b0, pos} + 7'd32 >= {1'b0, integer_length})) begin
            if (in_data < ob)      order_compare_next = CMP_LESS;
            else if (in_data > ob) order_compare_next = CMP_GREATER;
          end
          integer_bytes_left_next = left_dec;
          if (left_dec == 6'd0) begin
            if (order_compare_next != CMP_LESS) failed_next = 1'b1;
            if (!integer_number) begin
              integer_number_next = 1'b1;
              parse_phase_next    = PH_INT_TAG;
            end else begin
              parse_phase_next = PH_DONE;
            end
          end
        end
        default: begin
          // trailing bytes after the second integer
          failed_next = 1'b1;
        end
      endcase
    end

    res_next = !failed_next && (parse_phase_next == PH_DONE) &&
               (byte_count_next >= p256der_pkg::MIN_DER_BYTES) &&
               (byte_count_next <= p256der_pkg::MAX_DER_BYTES) &&
               ({1'b0, declared_length_next} == byte_count_next - 8'd2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid           <= 1'b0;
      out_valid          <= 1'b0;
      byte_count         <= 8'd0;
      parse_phase        <= PH_SEQ_TAG;
      declared_length    <= 7'd0;
      integer_number     <= 1'b0;
      integer_length     <= 6'd0;
      integer_bytes_left <= 6'd0;
      leading_zero_seen  <= 1'b0;
      order_compare      <= CMP_EQUAL;
      failed             <= 1'b0;
    end else begin
      // result register drains on a taken beat, refills from a final byte
      if (advance && in_last) begin
        out_valid <= 1'b1;
        out_res   <= res_next;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end

      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
        in_data  <= s_axis_tdata;
        in_last  <= s_axis_tlast;
      end

      if (advance) begin
        if (in_last) begin
          // the next byte opens a new signature
          byte_count         <= 8'd0;
          parse_phase        <= PH_SEQ_TAG;
          declared_length    <= 7'd0;
          integer_number     <= 1'b0;
          integer_length     <= 6'd0;
          integer_bytes_left <= 6'd0;
          leading_zero_seen  <= 1'b0;
          order_compare      <= CMP_EQUAL;
          failed             <= 1'b0;
        end else begin
          byte_count         <= byte_count_next;
          parse_phase        <= parse_phase_next;
          declared_length    <= declared_length_next;
          integer_number     <= integer_number_next;
          integer_length     <= integer_length_next;
          integer_bytes_left <= integer_bytes_left_next;
          leading_zero_seen  <= leading_zero_seen_next;
          order_compare      <= order_compare_next;
          failed             <= failed_next;
        end
      end
    end
  end

endmodule

`default_nettype wire

[sv/p256der_check.sv]
// p256der_check: port-level checks on the der signature check core, bound into every instance of the core
// depends on p256der_pkg and p256_ecdsa_der_signature_check_core
`default_nettype none

module p256der_check (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_axis_tready,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata
);

  // a held result beat keeps its verdict
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // only the verdict bit may be set
  a_out_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[p256der_pkg::DATA_W-1:1] == 7'd0)
    else $error("padding bits set in result beat");

  // input stalls only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output back-pressure");

  // reset leaves no result pending
  a_reset_clear: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result pending after reset");

endmodule

bind p256_ecdsa_der_signature_check_core p256der_check u_p256der_check (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

[test/tb_top.sv]
// tb_top: self-checking bench for p256_ecdsa_der_signature_check_core
// streams well-formed and broken der signatures, predicts each verdict, checks it
// depends on p256der_pkg and the core

module tb_top;

  localparam int CYCLE_LIMIT = 400000;

  // p-256 group order, most significant byte first
  localparam logic [7:0] P256_N [32] = '{
    8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00,
    8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
    8'hbc, 8'he6, 8'hfa, 8'had, 8'ha7, 8'h17, 8'h9e, 8'h84,
    8'hf3, 8'hb9, 8'hca, 8'hc2, 8'hfc, 8'h63, 8'h25, 8'h51
  };

  typedef enum logic [2:0] {
    PH_SEQ_TAG, PH_SEQ_LEN, PH_INT_TAG, PH_INT_LEN, PH_INT_BODY, PH_DONE
  } der_phase_e;

  typedef enum logic [1:0] {
    CMP_EQUAL, CMP_LESS, CMP_GREATER
  } order_cmp_e;

  // integer content shapes used by the generator
  typedef enum int {
    INT_RAW, INT_CANON, INT_NEAR_ORDER, INT_EXACT_ORDER, INT_ORDER_LESS_ONE
  } int_shape_e;

  // ways a generated signature gets broken
  typedef enum int {
    FLT_NONE, FLT_BIT_FLIP, FLT_TRUNCATE, FLT_TRAILING, FLT_SEQ_LEN,
    FLT_INT_LEN, FLT_TAG, FLT_OVERLONG
  } sig_fault_e;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } der_beat_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_valid = 1'b0;
  logic       s_ready;
  logic [7:0] s_data = 8'h00;
  logic       s_last = 1'b0;
  logic       m_valid;
  logic       m_ready = 1'b0;
  logic [7:0] m_data;

  der_beat_t  bytes_to_send [$];
  logic       verdicts_due [$];
  logic [7:0] sig_bytes [$];

  int send_idle_pct = 0;
  int ready_stall_pct = 0;
  int mismatches = 0;
  int cycles = 0;
  int bytes_queued = 0;
  int sigs_queued = 0;

  // predictor state
  logic [7:0] seen_bytes;
  der_phase_e phase_now;
  logic [6:0] seq_len_field;
  logic       int_index;
  logic [5:0] int_len;
  logic [5:0] int_left;
  logic       int_lead_zero;
  order_cmp_e n_compare;
  logic       sig_bad;

  always #1 clk = ~clk;

  p256_ecdsa_der_signature_check_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tlast  (s_last),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data)
  );

  task automatic report_mismatch(input string msg);
    if (mismatches < 40) $display("mismatch at cycle %0d: %s", cycles, msg);
    mismatches++;
  endtask

  function automatic void clear_parser();
    seen_bytes = 8'd0;
    phase_now = PH_SEQ_TAG;
    seq_len_field = 7'd0;
    int_index = 1'b0;
    int_len = 6'd0;
    int_left = 6'd0;
    int_lead_zero = 1'b0;
    n_compare = CMP_EQUAL;
    sig_bad = 1'b0;
  endfunction

  // one content byte of the current integer
  function automatic void integer_content(input logic [7:0] b);
    logic [5:0] pos;
    logic [4:0] oi;
    pos = int_len - int_left;
    if (pos == 6'd0) begin
      if (b[7]) sig_bad = 1'b1;
      if (int_len == 6'(p256der_pkg::INT_LEN_MAX) && b != 8'h00) sig_bad = 1'b1;
      if (int_len == 6'd1 && b == 8'h00) sig_bad = 1'b1;
      int_lead_zero = (b == 8'h00);
      // only a value as wide as the order needs comparing
      if (!(int_len == 6'(p256der_pkg::INT_LEN_MAX) ||
            (int_len == 6'(p256der_pkg::ORDER_BYTES) && b != 8'h00)))
        n_compare = CMP_LESS;
    end else if (pos == 6'd1) begin
      if (int_lead_zero && !b[7]) sig_bad = 1'b1;
    end
    if (n_compare == CMP_EQUAL && int'(pos) + 32 >= int'(int_len)) begin
      oi = 5'(int'(pos) + 32 - int'(int_len));
      if (b < P256_N[oi]) n_compare = CMP_LESS;
      else if (b > P256_N[oi]) n_compare = CMP_GREATER;
    end
    int_left = int_left - 6'd1;
    if (int_left == 6'd0) begin
      if (n_compare != CMP_LESS) sig_bad = 1'b1;
      if (!int_index) begin
        int_index = 1'b1;
        phase_now = PH_INT_TAG;
      end else begin
        phase_now = PH_DONE;
      end
    end
  endfunction

  // advance the predictor by one accepted byte; a verdict comes only on tlast
  function automatic void der_predict_byte(input logic [7:0] b, input logic is_last,
                                           output logic has_verdict, output logic verdict);
    if (seen_bytes != 8'hff) seen_bytes = seen_bytes + 8'd1;
    if (!sig_bad) begin
      case (phase_now)
        PH_SEQ_TAG: begin
          if (b != p256der_pkg::SEQ_TAG) sig_bad = 1'b1;
          phase_now = PH_SEQ_LEN;
        end
        PH_SEQ_LEN: begin
          if (b[7]) sig_bad = 1'b1;
          seq_len_field = b[6:0];
          phase_now = PH_INT_TAG;
        end
        PH_INT_TAG: begin
          if (b != p256der_pkg::INT_TAG) sig_bad = 1'b1;
          phase_now = PH_INT_LEN;
        end
        PH_INT_LEN: begin
          if (b == 8'h00 || b > p256der_pkg::INT_LEN_MAX) begin
            sig_bad = 1'b1;
          end else begin
            int_len = b[5:0];
            int_left = b[5:0];
            int_lead_zero = 1'b0;
            n_compare = CMP_EQUAL;
            phase_now = PH_INT_BODY;
          end
        end
        PH_INT_BODY: integer_content(b);
        default: sig_bad = 1'b1;
      endcase
    end
    has_verdict = is_last;
    verdict = 1'b0;
    if (is_last) begin
      verdict = !sig_bad && phase_now == PH_DONE &&
                seen_bytes >= p256der_pkg::MIN_DER_BYTES &&
                seen_bytes <= p256der_pkg::MAX_DER_BYTES &&
                int'(seq_len_field) == int'(seen_bytes) - 2;
      clear_parser();
    end
  endfunction

  // sender: takes pending bytes, idles at random
  always @(posedge clk) begin
    logic has_v;
    logic v;
    if (rst) begin
      s_valid <= 1'b0;
    end else begin
      if (s_valid && s_ready) begin
        der_predict_byte(s_data, s_last, has_v, v);
        if (has_v) verdicts_due.push_back(v);
      end
      if (!s_valid || s_ready) begin
        if (bytes_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_valid <= 1'b1;
          s_data  <= bytes_to_send[0].b;
          s_last  <= bytes_to_send[0].last;
          void'(bytes_to_send.pop_front());
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each verdict beat against the oldest prediction
  always @(posedge clk) begin
    logic [7:0] want;
    if (rst) begin
      m_ready <= 1'b0;
    end else begin
      if (m_valid && m_ready) begin
        if (verdicts_due.size() == 0) begin
          report_mismatch($sformatf("verdict beat %02h with none pending", m_data));
        end else begin
          want = {7'd0, verdicts_due.pop_front()};
          if (m_data !== want)
            report_mismatch($sformatf("verdict %02h, expected %02h", m_data, want));
        end
      end
      m_ready <= ($urandom_range(99) >= ready_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // integer of n content bytes, appended to sig_bytes in the given shape
  task automatic add_int(input int n, input int_shape_e shape);
    int base;
    int k;
    base = sig_bytes.size();
    for (int i = 0; i < n; i++) sig_bytes.push_back(8'($urandom_range(255)));
    case (shape)
      INT_CANON: begin
        if (n == 33) begin
          sig_bytes[base] = 8'h00;
          sig_bytes[base+1] = sig_bytes[base+1] | 8'h80;
        end else if (n >= 2 && $urandom_range(2) == 0) begin
          // sign pad before a byte with the top bit set
          sig_bytes[base] = 8'h00;
          sig_bytes[base+1] = sig_bytes[base+1] | 8'h80;
        end else begin
          sig_bytes[base] = 8'($urandom_range(8'h7f, 1));
        end
      end
      INT_NEAR_ORDER: begin
        // follow the order for k bytes, the byte at k is random
        k = $urandom_range(32);
        sig_bytes[base] = 8'h00;
        for (int j = 0; j < k && j + 1 < n; j++) sig_bytes[base+1+j] = P256_N[j];
      end
      INT_EXACT_ORDER, INT_ORDER_LESS_ONE: begin
        sig_bytes[base] = 8'h00;
        for (int j = 0; j < 32 && j + 1 < n; j++) sig_bytes[base+1+j] = P256_N[j];
        if (shape == INT_ORDER_LESS_ONE) sig_bytes[base+n-1] = 8'h50;
      end
      default: ;
    endcase
  endtask

  task automatic build_sig(input int nr, input int ns, input int_shape_e shr,
                           input int_shape_e shs, input sig_fault_e fault);
    int idx;
    int pad_to;
    sig_bytes.delete();
    sig_bytes.push_back(p256der_pkg::SEQ_TAG);
    sig_bytes.push_back(8'h00);
    sig_bytes.push_back(p256der_pkg::INT_TAG);
    sig_bytes.push_back(8'(nr));
    add_int(nr, shr);
    sig_bytes.push_back(p256der_pkg::INT_TAG);
    sig_bytes.push_back(8'(ns));
    add_int(ns, shs);
    sig_bytes[1] = 8'(sig_bytes.size() - 2);
    case (fault)
      FLT_BIT_FLIP: begin
        idx = $urandom_range(sig_bytes.size() - 1);
        sig_bytes[idx] = sig_bytes[idx] ^ (8'h01 << $urandom_range(7));
      end
      FLT_TRUNCATE: begin
        idx = $urandom_range(sig_bytes.size() - 1, 1);
        while (sig_bytes.size() > idx) void'(sig_bytes.pop_back());
      end
      FLT_TRAILING: begin
        idx = $urandom_range(3, 1);
        for (int i = 0; i < idx; i++) sig_bytes.push_back(8'($urandom_range(255)));
        if ($urandom_range(1) == 0) sig_bytes[1] = 8'(sig_bytes.size() - 2);
      end
      FLT_SEQ_LEN: begin
        if ($urandom_range(1) == 0) sig_bytes[1] = 8'($urandom_range(255));
        else sig_bytes[1] = sig_bytes[1] + 8'($urandom_range(3, 1));
      end
      FLT_INT_LEN: begin
        idx = ($urandom_range(1) == 0) ? 3 : 5 + nr;
        sig_bytes[idx] = ($urandom_range(1) == 0) ? 8'h00 : 8'($urandom_range(255, 34));
      end
      FLT_TAG: begin
        case ($urandom_range(2))
          0: idx = 0;
          1: idx = 2;
          default: idx = 4 + nr;
        endcase
        sig_bytes[idx] = 8'($urandom_range(255));
      end
      FLT_OVERLONG: begin
        pad_to = $urandom_range(90, 73);
        while (sig_bytes.size() < pad_to) sig_bytes.push_back(8'($urandom_range(255)));
        if ($urandom_range(1) == 0) sig_bytes[1] = 8'(sig_bytes.size() - 2);
      end
      default: ;
    endcase
  endtask

  task automatic finish_sig();
    der_beat_t beat;
    for (int i = 0; i < sig_bytes.size(); i++) begin
      beat.b = sig_bytes[i];
      beat.last = (i == sig_bytes.size() - 1);
      bytes_to_send.push_back(beat);
    end
    bytes_queued += sig_bytes.size();
    sigs_queued++;
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(4, 1);
    if (r < 80) return $urandom_range(33, 32);
    return $urandom_range(31, 5);
  endfunction

  function automatic int_shape_e pick_shape(input int n);
    int r;
    r = $urandom_range(99);
    if (r < 10) return INT_RAW;
    if (n != 33) return INT_CANON;
    if (r < 35) return INT_CANON;
    if (r < 95) return INT_NEAR_ORDER;
    return INT_EXACT_ORDER;
  endfunction

  task automatic random_sig();
    int nr;
    int ns;
    int r;
    sig_fault_e fault;
    nr = pick_len();
    ns = pick_len();
    r = $urandom_range(99);
    if (r < 60) fault = FLT_NONE;
    else if (r < 97) fault = sig_fault_e'($urandom_range(FLT_TAG, FLT_BIT_FLIP));
    else fault = FLT_OVERLONG;
    build_sig(nr, ns, pick_shape(nr), pick_shape(ns), fault);
    finish_sig();
  endtask

  // random bytes with random ends, closed by a tlast so the parser restarts
  task automatic noise_burst();
    int n;
    sig_bytes.delete();
    n = $urandom_range(6, 1);
    for (int i = 0; i < n; i++) sig_bytes.push_back(8'($urandom_range(255)));
    finish_sig();
  endtask

  task automatic directed_cases();
    // shortest and longest valid signatures
    build_sig(1, 1, INT_CANON, INT_CANON, FLT_NONE);
    finish_sig();
    build_sig(33, 33, INT_ORDER_LESS_ONE, INT_ORDER_LESS_ONE, FLT_NONE);
    finish_sig();
    // value equal to the order, then two canonical 32-byte values
    build_sig(33, 1, INT_EXACT_ORDER, INT_CANON, FLT_NONE);
    finish_sig();
    build_sig(1, 33, INT_CANON, INT_EXACT_ORDER, FLT_NONE);
    finish_sig();
    build_sig(32, 32, INT_CANON, INT_CANON, FLT_NONE);
    finish_sig();
    // zero value
    build_sig(1, 1, INT_CANON, INT_CANON, FLT_NONE);
    sig_bytes[4] = 8'h00;
    finish_sig();
    // negative value
    build_sig(2, 2, INT_CANON, INT_CANON, FLT_NONE);
    sig_bytes[4] = 8'h80;
    finish_sig();
    // redundant leading zero, then a proper sign pad
    build_sig(2, 1, INT_CANON, INT_CANON, FLT_NONE);
    sig_bytes[4] = 8'h00;
    sig_bytes[5] = 8'h01;
    finish_sig();
    build_sig(2, 1, INT_CANON, INT_CANON, FLT_NONE);
    sig_bytes[4] = 8'h00;
    sig_bytes[5] = 8'hff;
    finish_sig();
    // integer length of zero and of 34
    build_sig(1, 1, INT_CANON, INT_CANON, FLT_NONE);
    sig_bytes[3] = 8'h00;
    finish_sig();
    build_sig(1, 1, INT_CANON, INT_CANON, FLT_NONE);
    sig_bytes[3] = 8'd34;
    finish_sig();
    // sequence length in long form
    build_sig(1, 1, INT_CANON, INT_CANON, FLT_NONE);
    sig_bytes[1] = 8'h86;
    finish_sig();
    // trailing byte with a matching declared length
    build_sig(2, 2, INT_CANON, INT_CANON, FLT_NONE);
    sig_bytes.push_back(8'h00);
    sig_bytes[1] = 8'(sig_bytes.size() - 2);
    finish_sig();
    // early end inside the second integer
    build_sig(2, 2, INT_CANON, INT_CANON, FLT_NONE);
    void'(sig_bytes.pop_back());
    finish_sig();
    // lone bytes: the sequence tag and 8'hff
    sig_bytes = '{8'h30};
    finish_sig();
    sig_bytes = '{8'hff};
    finish_sig();
    // stream long enough to saturate the byte count
    build_sig(33, 33, INT_CANON, INT_CANON, FLT_NONE);
    while (sig_bytes.size() < 260) sig_bytes.push_back(8'h00);
    finish_sig();
  endtask

  task automatic wait_drained();
    while (bytes_to_send.size() != 0 || s_valid || verdicts_due.size() != 0)
      @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  initial begin
    clear_parser();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  ready_stall_pct = 0;  end
        1: begin send_idle_pct = 64; ready_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  ready_stall_pct = 64; end
        default: begin send_idle_pct = 31; ready_stall_pct = 31; end
      endcase
      bytes_queued = 0;
      sigs_queued = 0;
      if (ph == 0) directed_cases();
      while (bytes_queued < 32 || sigs_queued < 3) begin
        if ($urandom_range(99) < 12) noise_burst();
        else random_sig();
      end
      // sender holds off until every verdict so far is back
      wait_drained();
    end
    if (verdicts_due.size() != 0)
      report_mismatch($sformatf("%0d verdicts never arrived", verdicts_due.size()));
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
